// ===== rtl/core/htbd_pkg.sv =====
// Shared constants, codes and types for the Huffman tree-walk bit decoder.
package htbd_pkg;

  // Defaults for the top-level parameters.
  localparam int MaxSymbolsDef = 1024;
  localparam int SymbolBitsDef = 64;

  // Node numbers, counts and pad values.
  localparam int NodeW    = 11;
  localparam int IntCntW  = 10;
  localparam int PadW     = 4;
  localparam int ByteW    = 8;
  localparam int BitCntW  = 4;

  // Input item fields.
  localparam int CmdW     = 2;
  localparam int IdxW     = 10;
  localparam int ValW     = 64;
  localparam int SymOutW  = 64;

  // Slave tdata: command, table_index, table_value, stream_byte, zero pad.
  localparam int CmdLsb   = 0;
  localparam int IdxLsb   = CmdLsb + CmdW;
  localparam int ValLsb   = IdxLsb + IdxW;
  localparam int ByteLsb  = ValLsb + ValW;
  localparam int SFieldW  = ByteLsb + ByteW;
  localparam int STdataW  = ((SFieldW + 7) / 8) * 8;
  localparam int MTdataW  = SymOutW;

  // Configuration port.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 11;

  typedef enum logic [CmdW-1:0] {
    CMD_LEFT   = 2'd0,
    CMD_RIGHT  = 2'd1,
    CMD_SYMBOL = 2'd2,
    CMD_STREAM = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYMBOL_COUNT   = 1'b0,
    REG_INTERNAL_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_BIT   = 5'b00010,
    ST_NODE  = 5'b00100,
    ST_SYM   = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

endpackage

// ===== rtl/core/huffman_tree_bit_decoder.sv =====
// Huffman tree-walk decoder: node tables, bit-serial walk and output register.
//
// Usage
//   Slave stream carries one item per handshake. command selects a table
//   write (left child, right child, symbol) or a stream byte. Table writes
//   complete in the accepting cycle. The first stream byte after reset, or
//   after a byte with tlast set, is a header whose value is the pad count
//   (saturated to 8). Following bytes are coded data, MSB first; in the byte
//   with tlast set only 8 - pad bits are decoded.
//   Master stream carries one decoded symbol per item; tlast marks the final
//   symbol produced by a given input byte. A partial code at stream end is
//   dropped. The user must write the config port (symbol_count,
//   internal_count) only while idle; the block does not enforce this.
// Timing
//   The walk shifts the data byte out one bit at a time. Each bit passes
//   through ST_BIT, which reads the child tables at the current node, and
//   then ST_NODE, which takes the registered read data as the next node.
//   Each decoded symbol adds an ST_SYM step, which takes the registered
//   symbol table read, and a byte ends with an ST_FLUSH step. Decoding
//   speed is set by the dependent child-table read per bit. Table writes and
//   headers need no walk; s_axis_tready is high only between items.
// Reset and stall
//   Reset clears the walk state and expects a header next; table contents
//   are left as they are. The last symbol found is held one stage back until
//   its tlast is known; when the master side stalls, the walk waits at the
//   next symbol or at the flush until the output register frees up.
module huffman_tree_bit_decoder #(
  parameter int MAX_SYMBOLS = htbd_pkg::MaxSymbolsDef,
  parameter int SYMBOL_BITS = htbd_pkg::SymbolBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write port
  input  logic                         cfg_we_i,
  input  logic [htbd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [htbd_pkg::CfgDataW-1:0] cfg_data_i,
  // slave stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // command[1:0], table_index[11:2], table_value[75:12], stream_byte[83:76]
  input  logic [htbd_pkg::STdataW-1:0] s_axis_tdata,
  input  logic                         s_axis_tlast,   // last_byte
  // master stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [htbd_pkg::MTdataW-1:0] m_axis_tdata,  // symbol[63:0]
  output logic                         m_axis_tlast    // last_of_byte
);
  import htbd_pkg::*;

  localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  // Node tables
  logic [NodeW-1:0]       left_mem  [MAX_SYMBOLS];
  logic [NodeW-1:0]       right_mem [MAX_SYMBOLS];
  logic [SYMBOL_BITS-1:0] sym_mem   [MAX_SYMBOLS];

  // Config
  logic [NodeW-1:0]   sym_cnt_q;
  logic [IntCntW-1:0] int_cnt_q;
  logic [NodeW-1:0]   root;

  // Control
  state_e             state_q, state_d;
  logic               await_hdr_q;
  logic [PadW-1:0]    pad_q;
  logic [NodeW-1:0]   node_q;
  logic [BitCntW-1:0] bits_left_q;
  logic               hold_valid_q;
  logic               out_valid_q;

  // Payload
  logic [ByteW-1:0]       byte_q;
  logic                   bit_q;
  logic                   ti_ok_q;
  logic                   si_ok_q;
  logic                   out_last_q;
  logic [SymOutW-1:0]     hold_sym_q;
  logic [SymOutW-1:0]     out_sym_q;
  logic [NodeW-1:0]       left_rd_q, right_rd_q;
  logic [SYMBOL_BITS-1:0] sym_rd_q;

  // Input fields
  cmd_e             in_cmd;
  logic [IdxW-1:0]  in_idx;
  logic [ValW-1:0]  in_val;
  logic [ByteW-1:0] in_byte;
  logic             accept;
  logic             wr_ok;
  logic [AW-1:0]    wr_addr;

  // Walk datapath
  logic [NodeW+1:0] ti_diff;
  logic             ti_ok;
  logic [AW-1:0]    ti_addr;
  logic [NodeW-1:0] next_node;
  logic             is_leaf;
  logic [NodeW-1:0] si;
  logic             si_ok;
  logic [SymOutW-1:0] sym_val;

  // Output push
  logic               out_free;
  logic               push;
  logic               push_last;
  logic               rd_child;
  logic               rd_sym;

  assign in_cmd  = cmd_e'(s_axis_tdata[CmdLsb +: CmdW]);
  assign in_idx  = s_axis_tdata[IdxLsb +: IdxW];
  assign in_val  = s_axis_tdata[ValLsb +: ValW];
  assign in_byte = s_axis_tdata[ByteLsb +: ByteW];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wr_ok         = 32'(in_idx) < 32'(MAX_SYMBOLS);
  assign wr_addr       = AW'(in_idx);

  assign root = NodeW'(sym_cnt_q + NodeW'(int_cnt_q));

  // Child-table index: node - symbol_count - 1; negative means out of range.
  assign ti_diff = {2'b00, node_q} - {2'b00, sym_cnt_q} - (NodeW+2)'(1);
  assign ti_ok   = !ti_diff[NodeW+1] && (32'(ti_diff[NodeW:0]) < 32'(MAX_SYMBOLS));
  assign ti_addr = AW'(ti_diff[NodeW:0]);

  assign next_node = ti_ok_q ? (bit_q ? right_rd_q : left_rd_q) : '0;
  assign is_leaf   = next_node <= sym_cnt_q;
  assign si        = next_node - NodeW'(1);
  assign si_ok     = (next_node != '0) && (32'(si) < 32'(MAX_SYMBOLS));

  // Stored symbols are sign-extended to the output width.
  assign sym_val = si_ok_q ? SymOutW'($signed(sym_rd_q)) : '0;

  assign out_free = !out_valid_q || m_axis_tready;
  assign rd_child = (state_q == ST_BIT) && (bits_left_q != '0);
  assign rd_sym   = (state_q == ST_NODE) && is_leaf;

  // A held symbol goes out when a newer one arrives (not last) or at flush.
  always_comb begin
    push      = 1'b0;
    push_last = 1'b0;
    if (hold_valid_q && out_free) begin
      if (state_q == ST_SYM) begin
        push = 1'b1;
      end else if (state_q == ST_FLUSH) begin
        push      = 1'b1;
        push_last = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_cmd == CMD_STREAM) && !await_hdr_q) begin
          state_d = ST_BIT;
        end
      end
      ST_BIT: begin
        state_d = (bits_left_q == '0) ? ST_FLUSH : ST_NODE;
      end
      ST_NODE: begin
        state_d = is_leaf ? ST_SYM : ST_BIT;
      end
      ST_SYM: begin
        if (!hold_valid_q || out_free) begin
          state_d = ST_BIT;
        end
      end
      ST_FLUSH: begin
        if (!hold_valid_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Table memories
  always_ff @(posedge clk_i) begin
    if (accept && wr_ok) begin
      if (in_cmd == CMD_LEFT) begin
        left_mem[wr_addr] <= in_val[NodeW-1:0];
      end
      if (in_cmd == CMD_RIGHT) begin
        right_mem[wr_addr] <= in_val[NodeW-1:0];
      end
      if (in_cmd == CMD_SYMBOL) begin
        sym_mem[wr_addr] <= in_val[SYMBOL_BITS-1:0];
      end
    end
    if (rd_child) begin
      left_rd_q  <= left_mem[ti_addr];
      right_rd_q <= right_mem[ti_addr];
    end
    if (rd_sym) begin
      sym_rd_q <= sym_mem[AW'(si)];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      sym_cnt_q    <= NodeW'(1);
      int_cnt_q    <= '0;
      await_hdr_q  <= 1'b1;
      pad_q        <= '0;
      node_q       <= '0;
      bits_left_q  <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_SYMBOL_COUNT:   sym_cnt_q <= cfg_data_i[NodeW-1:0];
          REG_INTERNAL_COUNT: int_cnt_q <= cfg_data_i[IntCntW-1:0];
          default: ;
        endcase
      end
      if (accept && (in_cmd == CMD_STREAM)) begin
        if (await_hdr_q) begin
          pad_q       <= (in_byte > ByteW'(8)) ? PadW'(8) : PadW'(in_byte);
          node_q      <= root;
          await_hdr_q <= s_axis_tlast;
        end else begin
          bits_left_q <= s_axis_tlast ? (BitCntW'(8) - BitCntW'(pad_q)) : BitCntW'(8);
          await_hdr_q <= s_axis_tlast;
        end
      end
      if (state_q == ST_NODE) begin
        bits_left_q <= bits_left_q - BitCntW'(1);
        node_q      <= is_leaf ? root : next_node;
      end
      if ((state_q == ST_SYM) && (!hold_valid_q || out_free)) begin
        hold_valid_q <= 1'b1;
      end
      if (push_last) begin
        hold_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte;
    end else if (state_q == ST_NODE) begin
      byte_q <= {byte_q[ByteW-2:0], 1'b0};
    end
    if (state_q == ST_BIT) begin
      bit_q   <= byte_q[ByteW-1];
      ti_ok_q <= ti_ok;
    end
    if (rd_sym) begin
      si_ok_q <= si_ok;
    end
    if ((state_q == ST_SYM) && (!hold_valid_q || out_free)) begin
      hold_sym_q <= sym_val;
    end
    if (push) begin
      out_sym_q  <= hold_sym_q;
      out_last_q <= push_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sym_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/core/htbd_checker.sv =====
// Port-level checks for the Huffman tree-walk decoder, bound to the top level.
module htbd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [htbd_pkg::CfgIdxW-1:0] cfg_index_i,
  input logic [htbd_pkg::CfgDataW-1:0] cfg_data_i,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [htbd_pkg::STdataW-1:0] s_axis_tdata,
  input logic                         s_axis_tlast,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [htbd_pkg::MTdataW-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);
  import htbd_pkg::*;

  // Stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // After a table write the block stays ready.
  a_tbl_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[CmdLsb +: CmdW] != CMD_STREAM)
      |=> s_axis_tready)
    else $error("not ready after table write");

  // A new result is only produced while a byte is being decoded.
  a_out_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while idle");

endmodule

bind huffman_tree_bit_decoder htbd_checker u_htbd_checker (.*);
